// ----- rtl/core/kpclk_pkg.sv -----
// Package for the keypad-settable time-of-day clock.
// Holds the input and result word types, key constants and status codes.
// No dependencies; every other file in rtl/core imports it.
package kpclk_pkg;

  // Kind of input word.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_KEY  = 1'b1;

  // ASCII codes of interest.
  localparam logic [7:0] KEY_START  = 8'd49;  // '1'
  localparam logic [7:0] ASCII_ZERO = 8'd48;  // '0'
  localparam logic [7:0] ASCII_NINE = 8'd57;  // '9'

  // Time limits.
  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [5:0] SEC_MAX  = 6'd59;

  // Entry phases: idle, then one phase per digit awaited.
  localparam logic [2:0] PHASE_IDLE = 3'd0;
  localparam logic [2:0] PHASE_LAST = 3'd6;
  localparam int unsigned NUM_STORED = 5;  // the sixth digit is used directly

  typedef enum logic [2:0] {
    ST_RUN       = 3'd0,
    ST_ENTERING  = 3'd1,
    ST_WRONG_KEY = 3'd2,
    ST_BAD_HOUR  = 3'd3,
    ST_BAD_MIN   = 3'd4,
    ST_BAD_SEC   = 3'd5,
    ST_SET       = 3'd6
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] key_code;
  } item_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [2:0] entry_step;
    status_t    status;
  } result_t;

endpackage

// ----- rtl/core/kpclk_engine.sv -----
// Time and entry state of the keypad-settable clock, with its update logic.
// Applies one input word per step strobe and presents the updated result.
// Depends on kpclk_pkg.
module kpclk_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  kpclk_pkg::item_t  item,
  output kpclk_pkg::result_t result
);
  import kpclk_pkg::*;

  logic [5:0] sec_count, sec_next;
  logic [5:0] min_count, min_next;
  logic [4:0] hour_count, hour_next;
  logic [2:0] entry_phase, phase_next;
  logic [3:0] digit_store [NUM_STORED];
  logic       store_we;
  logic [2:0] store_idx;
  logic       is_digit;
  logic [3:0] digit;
  logic [6:0] h_val, m_val, s_val;
  status_t    status;

  // Two decimal digits to binary: hi * 10 + lo, as shifts and adds.
  function automatic logic [6:0] pair_value(input logic [3:0] hi, input logic [3:0] lo);
    logic [6:0] r;
    r = {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
    return r;
  endfunction

  assign is_digit  = (item.key_code >= ASCII_ZERO) && (item.key_code <= ASCII_NINE);
  assign digit     = item.key_code[3:0];
  assign store_idx = entry_phase - 3'd1;

  assign h_val = pair_value(digit_store[0], digit_store[1]);
  assign m_val = pair_value(digit_store[2], digit_store[3]);
  assign s_val = pair_value(digit_store[4], digit);

  // Next state and status for the word being applied.
  always_comb begin
    sec_next   = sec_count;
    min_next   = min_count;
    hour_next  = hour_count;
    phase_next = entry_phase;
    store_we   = 1'b0;
    status     = ST_RUN;
    if (item.kind == KIND_TICK) begin
      // Seconds roll into minutes, minutes into hours, hours wrap at midnight.
      if (sec_count >= SEC_MAX) begin
        sec_next = '0;
        if (min_count >= MIN_MAX) begin
          min_next = '0;
          if (hour_count >= HOUR_MAX) begin
            hour_next = '0;
          end else begin
            hour_next = hour_count + 5'd1;
          end
        end else begin
          min_next = min_count + 6'd1;
        end
      end else begin
        sec_next = sec_count + 6'd1;
      end
      status = (entry_phase != PHASE_IDLE) ? ST_ENTERING : ST_RUN;
    end else if (entry_phase == PHASE_IDLE) begin
      if (item.key_code == KEY_START) begin
        phase_next = 3'd1;
        status     = ST_ENTERING;
      end else begin
        status = ST_WRONG_KEY;
      end
    end else if (!is_digit || entry_phase > PHASE_LAST) begin
      phase_next = PHASE_IDLE;
      status     = ST_WRONG_KEY;
    end else if (entry_phase < PHASE_LAST) begin
      store_we   = 1'b1;
      phase_next = entry_phase + 3'd1;
      status     = ST_ENTERING;
    end else begin
      // Last digit: check fields in order and load only if all are in range.
      phase_next = PHASE_IDLE;
      if (h_val > {2'b00, HOUR_MAX}) begin
        status = ST_BAD_HOUR;
      end else if (m_val > {1'b0, MIN_MAX}) begin
        status = ST_BAD_MIN;
      end else if (s_val > {1'b0, SEC_MAX}) begin
        status = ST_BAD_SEC;
      end else begin
        hour_next = h_val[4:0];
        min_next  = m_val[5:0];
        sec_next  = s_val[5:0];
        status    = ST_SET;
      end
    end
  end

  // Result as seen after the update.
  always_comb begin
    result.hours      = hour_next;
    result.minutes    = min_next;
    result.seconds    = sec_next;
    result.entry_step = (phase_next != PHASE_IDLE) ? (phase_next - 3'd1) : 3'd0;
    result.status     = status;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_count   <= '0;
      min_count   <= '0;
      hour_count  <= '0;
      entry_phase <= PHASE_IDLE;
    end else if (step) begin
      sec_count   <= sec_next;
      min_count   <= min_next;
      hour_count  <= hour_next;
      entry_phase <= phase_next;
    end
  end

  // Digit store has no reset: every entry is written before it is read.
  always_ff @(posedge clk) begin
    if (step && store_we) begin
      digit_store[store_idx] <= digit;
    end
  end

endmodule

// ----- rtl/core/keypad_set_time_of_day_clock_unit.sv -----
// Top level of the keypad-settable 24-hour time-of-day clock.
// Depends on kpclk_pkg and kpclk_engine.
//
// Each input word is either a one-second tick or a key press, and each gives
// exactly one result word carrying the time after the update, the number of
// digits entered so far and a status code. The block takes one word per clock
// while the result register is not stalled, and returns results in order; an
// accepted word waits in the input register and is then applied and written
// into the result register once that register is free or being emptied.
// The time and entry state in kpclk_engine are updated as each word is applied.
// A stalled result register holds one result while the input register holds
// the next word.
module keypad_set_time_of_day_clock_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  kpclk_pkg::item_t   in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output kpclk_pkg::result_t out_word
);
  import kpclk_pkg::*;

  logic    in_held;
  item_t   in_q;
  logic    advance;
  result_t result;

  // A held word is applied when the result register is free or being emptied.
  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_word;
    end
  end

  kpclk_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_q),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  // The reported time is always a valid time of day.
  a_time_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.hours <= HOUR_MAX) && (out_word.minutes <= MIN_MAX) &&
                  (out_word.seconds <= SEC_MAX))
    else $error("result time out of range");

  // Any status that ends or refuses entry reports no digits pending.
  a_step_cleared: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status == ST_WRONG_KEY || out_word.status == ST_BAD_HOUR ||
                  out_word.status == ST_BAD_MIN || out_word.status == ST_SET ||
                  out_word.status == ST_BAD_SEC || out_word.status == ST_RUN)
    |-> (out_word.entry_step == 3'd0))
    else $error("entry step not cleared");

  // No more than five digits are ever reported as pending.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.entry_step <= 3'd5))
    else $error("entry step beyond five");

  // A held word that cannot be applied stays held.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_held && !advance |=> in_held && $stable(in_q))
    else $error("held input word lost");

endmodule

// ----- bench/keypad_set_time_of_day_clock_unit_test.sv -----
// Self-checking bench for the keypad-settable 24-hour time-of-day clock.
// Depends on kpclk_pkg and keypad_set_time_of_day_clock_unit; predicts every
// result word from its own model of the clock and the keypad entry sequence.
module keypad_set_time_of_day_clock_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kpclk_pkg::*;

  localparam logic [2:0] PHASE_FIRST = 3'd1;
  localparam int RANDOM_WORDS = 1500;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_ready;
  item_t   in_word;
  logic    out_valid;
  logic    out_ready;
  result_t out_word;

  // Model of the clock and of the keypad entry.
  logic [4:0] tod_hours;
  logic [5:0] tod_minutes;
  logic [5:0] tod_seconds;
  logic [2:0] digit_phase;
  logic [3:0] keyed_digits [6];

  result_t expected_display [$];
  int      words_sent;
  int      mismatches;
  int      burst_left;
  int      quiet_cycles;

  keypad_set_time_of_day_clock_unit uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  // Free-running 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the display after one word and updates the model state.
  function automatic result_t predict_display(item_t w);
    result_t r;
    status_t st;
    int      hh;
    int      mm;
    int      ss;
    st = ST_RUN;
    if (w.kind == KIND_TICK) begin
      if (tod_seconds == SEC_MAX) begin
        tod_seconds = '0;
        if (tod_minutes == MIN_MAX) begin
          tod_minutes = '0;
          tod_hours = (tod_hours == HOUR_MAX) ? 5'd0 : 5'(tod_hours + 5'd1);
        end else begin
          tod_minutes = 6'(tod_minutes + 6'd1);
        end
      end else begin
        tod_seconds = 6'(tod_seconds + 6'd1);
      end
      st = (digit_phase != PHASE_IDLE) ? ST_ENTERING : ST_RUN;
    end else if (digit_phase == PHASE_IDLE) begin
      if (w.key_code == KEY_START) begin
        digit_phase = PHASE_FIRST;
        st = ST_ENTERING;
      end else begin
        st = ST_WRONG_KEY;
      end
    end else if (w.key_code < ASCII_ZERO || w.key_code > ASCII_NINE) begin
      digit_phase = PHASE_IDLE;
      st = ST_WRONG_KEY;
    end else begin
      keyed_digits[digit_phase - PHASE_FIRST] = 4'(w.key_code - ASCII_ZERO);
      if (digit_phase != PHASE_LAST) begin
        digit_phase = 3'(digit_phase + 3'd1);
        st = ST_ENTERING;
      end else begin
        hh = keyed_digits[0] * 10 + keyed_digits[1];
        mm = keyed_digits[2] * 10 + keyed_digits[3];
        ss = keyed_digits[4] * 10 + keyed_digits[5];
        digit_phase = PHASE_IDLE;
        if (hh > HOUR_MAX) begin
          st = ST_BAD_HOUR;
        end else if (mm > MIN_MAX) begin
          st = ST_BAD_MIN;
        end else if (ss > SEC_MAX) begin
          st = ST_BAD_SEC;
        end else begin
          tod_hours = 5'(hh);
          tod_minutes = 6'(mm);
          tod_seconds = 6'(ss);
          st = ST_SET;
        end
      end
    end
    r.hours = tod_hours;
    r.minutes = tod_minutes;
    r.seconds = tod_seconds;
    r.entry_step = (digit_phase != PHASE_IDLE) ? 3'(digit_phase - PHASE_FIRST) : 3'd0;
    r.status = st;
    return r;
  endfunction

  // Sends one word in bursts with random gaps, and records its prediction
  // once it has been accepted.
  task automatic send_word(item_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0)
        gap = 0;
      else if ($urandom_range(0, 7) == 0)
        gap = $urandom_range(6, 30);
      else
        gap = $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    expected_display.push_back(predict_display(w));
    words_sent++;
  endtask

  task automatic tick();
    item_t w;
    w.kind = KIND_TICK;
    w.key_code = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  task automatic press(logic [7:0] code);
    item_t w;
    w.kind = KIND_KEY;
    w.key_code = code;
    send_word(w);
  endtask

  // Keys in a start key and six digits for HH MM SS, with ticks mixed in
  // and a chance of breaking the entry off with a non-digit key.
  task automatic key_in_time(int hh, int mm, int ss, int tick_pct, int abort_pct);
    logic [7:0] chars [6];
    logic [7:0] stray;
    chars[0] = ASCII_ZERO + 8'(hh / 10);
    chars[1] = ASCII_ZERO + 8'(hh % 10);
    chars[2] = ASCII_ZERO + 8'(mm / 10);
    chars[3] = ASCII_ZERO + 8'(mm % 10);
    chars[4] = ASCII_ZERO + 8'(ss / 10);
    chars[5] = ASCII_ZERO + 8'(ss % 10);
    press(KEY_START);
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(1, 100) <= tick_pct)
        tick();
      if ($urandom_range(1, 100) <= abort_pct) begin
        do stray = 8'($urandom_range(0, 255));
        while (stray >= ASCII_ZERO && stray <= ASCII_NINE);
        press(stray);
        return;
      end
      press(chars[i]);
    end
  endtask

  // Compares one field of a result word and reports any difference.
  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Checks every accepted result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_display.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
        mismatches++;
      end else begin
        result_t want;
        want = expected_display.pop_front();
        compare_field("hours", want.hours, out_word.hours);
        compare_field("minutes", want.minutes, out_word.minutes);
        compare_field("seconds", want.seconds, out_word.seconds);
        compare_field("entry_step", want.entry_step, out_word.entry_step);
        compare_field("status", want.status, out_word.status);
      end
    end
  end

  // Receiver: runs of ready broken by stalls of varying length.
  initial begin
    int ready_run;
    int stall_len;
    out_ready = 1'b0;
    forever begin
      ready_run = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 150 : 25);
      repeat (ready_run) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      stall_len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      repeat (stall_len) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Counting from reset through a set time to the midnight wrap.
  task automatic test_midnight_rollover();
    tick();
    key_in_time(23, 59, 59, 0, 0);
    tick();
  endtask

  // Wrong key while idle, and aborted entries with keys below and above the digits.
  task automatic test_wrong_keys();
    press(8'hFF);
    press(KEY_START);
    tick();
    press(8'h00);
    press(KEY_START);
    press(ASCII_ZERO);
    press(ASCII_NINE + 8'd1);
  endtask

  // A complete entry whose hours are out of range leaves the time alone.
  task automatic test_out_of_range();
    key_in_time(99, 0, 0, 0, 0);
  endtask

  // Mostly well-formed entries with random times, tick runs and stray keys.
  task automatic test_random_traffic();
    int target;
    int pick;
    int sel;
    int hh;
    int mm;
    int ss;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        sel = $urandom_range(0, 9);
        hh = $urandom_range(0, 23);
        mm = $urandom_range(0, 59);
        ss = $urandom_range(0, 59);
        case (sel)
          0: hh = $urandom_range(24, 99);
          1: mm = $urandom_range(60, 99);
          2: ss = $urandom_range(60, 99);
          3, 4: begin
            mm = 59;
            ss = $urandom_range(50, 59);
            if (sel == 4)
              hh = 23;
          end
          default: ;
        endcase
        key_in_time(hh, mm, ss, 15, 4);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 80)) tick();
      end else begin
        press(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Main sequence: reset once, run each test, then drain and report.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    tod_hours = '0;
    tod_minutes = '0;
    tod_seconds = '0;
    digit_phase = PHASE_IDLE;
    words_sent = 0;
    mismatches = 0;
    burst_left = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_midnight_rollover();
    test_wrong_keys();
    test_out_of_range();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_display.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
